FILE: rtl/core/lcdpws_pkg.sv
// shared types and constants for the lcd pixel write sequencer
// no dependencies; compiled first

package lcdpws_pkg;

    localparam int COORD_W   = 9;
    localparam int LEVEL_W   = 8;
    localparam int BYTE_W    = 8;
    localparam int MODE_W    = 2;
    localparam int SEQ_LEN   = 14;

    localparam logic [BYTE_W-1:0] CMD_COLUMN_SET = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_ROW_SET    = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_MEM_WRITE  = 8'h2C;

    localparam logic [MODE_W-1:0] MODE_RGB444 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RGB565 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RGB666 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_RGB565;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] link_byte;
        logic              is_command;
        logic              last_byte;
    } t_link_cell;

    localparam t_link_cell EMPTY_CELL = '{valid: 1'b0, link_byte: '0,
                                         is_command: 1'b0, last_byte: 1'b0};

    // one cell entry for a byte in the stream
    function automatic t_link_cell make_cell(input logic [BYTE_W-1:0] b,
                                             input logic cmd,
                                             input logic last);
        t_link_cell c;
        c.valid      = 1'b1;
        c.link_byte  = b;
        c.is_command = cmd;
        c.last_byte  = last;
        return c;
    endfunction

endpackage

FILE: rtl/core/lcdpws_pixel_if.sv
// pixel write channel: valid/ready handshake with coordinates and color
// depends on lcdpws_pkg

interface lcdpws_pixel_if import lcdpws_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;

    modport source (output valid, column, row, red_level, green_level, blue_level,
                    input ready);
    modport sink   (input valid, column, row, red_level, green_level, blue_level,
                    output ready);
endinterface

FILE: rtl/core/lcdpws_byte_if.sv
// link byte channel: valid/ready handshake with byte, command flag and last mark
// depends on lcdpws_pkg

interface lcdpws_byte_if import lcdpws_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] link_byte;
    logic              is_command;
    logic              last_byte;

    modport source (output valid, link_byte, is_command, last_byte, input ready);
    modport sink   (input valid, link_byte, is_command, last_byte, output ready);
endinterface

FILE: rtl/core/lcdpws_packer.sv
// builds the full byte sequence for one pixel write in parallel
// depends on lcdpws_pkg

module lcdpws_packer import lcdpws_pkg::*; (
    input  logic [COORD_W-1:0] i_column,
    input  logic [COORD_W-1:0] i_row,
    input  logic [LEVEL_W-1:0] i_red,
    input  logic [LEVEL_W-1:0] i_green,
    input  logic [LEVEL_W-1:0] i_blue,
    input  logic [MODE_W-1:0]  i_mode,
    output t_link_cell         o_seq [SEQ_LEN]
);

    logic [BYTE_W-1:0] col_hi, col_lo, row_hi, row_lo;
    logic [BYTE_W-1:0] px0, px1;
    logic              wide;

    assign col_hi = BYTE_W'(i_column >> BYTE_W);
    assign col_lo = i_column[BYTE_W-1:0];
    assign row_hi = BYTE_W'(i_row >> BYTE_W);
    assign row_lo = i_row[BYTE_W-1:0];
    // mode 3 falls in with 18-bit packing
    assign wide   = i_mode[1];

    always_comb begin
        if (i_mode == MODE_RGB565) begin
            px0 = {i_red[7:3], i_green[7:5]};
            px1 = {i_green[4:2], i_blue[7:3]};
        end else begin
            px0 = {i_red[7:4], i_green[7:4]};
            px1 = {i_blue[7:4], 4'h0};
        end
    end

    always_comb begin
        o_seq[0]  = make_cell(CMD_COLUMN_SET, 1'b1, 1'b0);
        o_seq[1]  = make_cell(col_hi, 1'b0, 1'b0);
        o_seq[2]  = make_cell(col_lo, 1'b0, 1'b0);
        o_seq[3]  = make_cell(col_hi, 1'b0, 1'b0);
        o_seq[4]  = make_cell(col_lo, 1'b0, 1'b0);
        o_seq[5]  = make_cell(CMD_ROW_SET, 1'b1, 1'b0);
        o_seq[6]  = make_cell(row_hi, 1'b0, 1'b0);
        o_seq[7]  = make_cell(row_lo, 1'b0, 1'b0);
        o_seq[8]  = make_cell(row_hi, 1'b0, 1'b0);
        o_seq[9]  = make_cell(row_lo, 1'b0, 1'b0);
        o_seq[10] = make_cell(CMD_MEM_WRITE, 1'b1, 1'b0);
        if (wide) begin
            o_seq[11] = make_cell({i_red[7:2], 2'b00}, 1'b0, 1'b0);
            o_seq[12] = make_cell({i_green[7:2], 2'b00}, 1'b0, 1'b0);
            o_seq[13] = make_cell({i_blue[7:2], 2'b00}, 1'b0, 1'b1);
        end else begin
            o_seq[11] = make_cell(px0, 1'b0, 1'b0);
            o_seq[12] = make_cell(px1, 1'b0, 1'b1);
            o_seq[13] = EMPTY_CELL;
        end
    end

endmodule

FILE: rtl/core/lcdpws_cell.sv
// one stage of the byte chain: loads a byte, holds it, or takes its neighbor's
// depends on lcdpws_pkg

module lcdpws_cell import lcdpws_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic       i_shift,
    input  t_link_cell i_load_data,
    input  t_link_cell i_next_data,
    output t_link_cell o_data
);

    logic              r_valid, n_valid;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_cmd, n_cmd;
    logic              r_last, n_last;

    always_comb begin
        priority if (i_load) begin
            n_valid = i_load_data.valid;
            n_byte  = i_load_data.link_byte;
            n_cmd   = i_load_data.is_command;
            n_last  = i_load_data.last_byte;
        end else if (i_shift) begin
            n_valid = i_next_data.valid;
            n_byte  = i_next_data.link_byte;
            n_cmd   = i_next_data.is_command;
            n_last  = i_next_data.last_byte;
        end else begin
            n_valid = r_valid;
            n_byte  = r_byte;
            n_cmd   = r_cmd;
            n_last  = r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_cmd  <= n_cmd;
        r_last <= n_last;
    end

    assign o_data.valid      = r_valid;
    assign o_data.link_byte  = r_byte;
    assign o_data.is_command = r_cmd;
    assign o_data.last_byte  = r_last;

endmodule

FILE: rtl/core/lcd_pixel_write_sequencer.sv
// top level of the lcd pixel write sequencer: color mode register, packer,
// and a chain of fifteen byte cells; depends on lcdpws_pkg, the two channel
// interfaces, lcdpws_packer and lcdpws_cell
//
// Usage:
//   i_pix takes one pixel write (column, row, red/green/blue levels). Each
//   transfer expands into a byte stream on o_byte: 0x2A and the column twice
//   as big-endian start/end, 0x2B and the row the same way, 0x2C, then the
//   packed pixel (2 bytes for 12/16-bit modes, 3 bytes for 18-bit).
//   is_command flags command bytes; last_byte marks the end of a pixel.
//   i_cfg_we/i_cfg_wdata write the color mode; change it only while idle.
// Timing:
//   a transfer loads cells 1..14; cell 0 is the output register, so the first
//   byte reaches o_byte once a shift moves it from cell 1 into cell 0.
//   The next pixel is taken when cell 1 is empty, or when it holds the previous
//   final byte and the chain moves, so bytes leave back to back while o_byte is
//   ready: 13 bytes per pixel in 12/16-bit modes, 14 in 18-bit mode.
// Reset: all cells empty, color mode 16-bit. A stalled receiver freezes the
//   whole chain and holds input ready low while cell 1 is occupied.

module lcd_pixel_write_sequencer import lcdpws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lcdpws_pixel_if.sink      i_pix,
    lcdpws_byte_if.source     o_byte,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_wdata
);

    localparam int CHAIN_LEN = SEQ_LEN + 1;

    logic [MODE_W-1:0] r_color_mode;
    t_link_cell        packed_seq [SEQ_LEN];
    t_link_cell        chain      [CHAIN_LEN];
    logic              accept;
    logic              shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            r_color_mode <= i_cfg_wdata;
        end
    end

    lcdpws_packer u_packer (
        .i_column (i_pix.column),
        .i_row    (i_pix.row),
        .i_red    (i_pix.red_level),
        .i_green  (i_pix.green_level),
        .i_blue   (i_pix.blue_level),
        .i_mode   (r_color_mode),
        .o_seq    (packed_seq)
    );

    // bytes stay packed toward cell 0: with cell 2 empty, cell 1 holds at most the
    // final byte, which moves into cell 0 on a shift while the new pixel loads
    assign i_pix.ready = !chain[1].valid || (!chain[2].valid && shift);
    assign accept      = i_pix.valid && i_pix.ready;
    assign shift       = !chain[0].valid || o_byte.ready;

    lcdpws_cell u_cell_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (1'b0),
        .i_shift     (shift),
        .i_load_data (EMPTY_CELL),
        .i_next_data (chain[1]),
        .o_data      (chain[0])
    );

    for (genvar k = 1; k < CHAIN_LEN; k++) begin : g_cell
        lcdpws_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (accept),
            .i_shift     (shift),
            .i_load_data (packed_seq[k-1]),
            .i_next_data ((k == CHAIN_LEN - 1) ? EMPTY_CELL : chain[(k + 1) % CHAIN_LEN]),
            .o_data      (chain[k])
        );
    end

    assign o_byte.valid      = chain[0].valid;
    assign o_byte.link_byte  = chain[0].link_byte;
    assign o_byte.is_command = chain[0].is_command;
    assign o_byte.last_byte  = chain[0].last_byte;

    // a transfer lands the column-address command right behind the output register
    a_load_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> chain[1].valid && chain[1].is_command &&
                   chain[1].link_byte == CMD_COLUMN_SET)
        else $error("pixel transfer did not load the column command into cell 1");

    // a byte that is not the last of its pixel always has a successor behind it
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain[0].valid && !chain[0].last_byte |-> chain[1].valid)
        else $error("gap in the byte chain inside a pixel sequence");

    // behind a last byte there is either nothing or the start of the next pixel
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain[0].valid && chain[0].last_byte |->
            !chain[1].valid ||
            (chain[1].is_command && chain[1].link_byte == CMD_COLUMN_SET))
        else $error("unexpected byte behind the last byte of a pixel");

endmodule
